>>> rtl/otti_pkg.sv
// ---------------------------------------------------------------------------
// otti_pkg
// shared constants and controller/datapath command and status types
// ---------------------------------------------------------------------------
package otti_pkg;

    localparam int STORE_WORDS_DEF  = 1024;
    localparam int LIFETIME_MAX_DEF = 64;
    localparam logic [6:0]  LIFETIME_RESET = 7'd60;
    localparam logic [31:0] COUNTER_LIMIT  = 32'hffff_ffff - 32'd31;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RATE    = 2'd3;

    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_CLAIM   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch input word
        logic mod_start;  // start remainder unit
        logic mod_sel;    // 0: remainder of bucket / cursor, 1: of horizon
        logic off_rd;     // read offset at remainder result
        logic cur_rd;     // read offset of cursor slot
        logic word_rd;    // read claim word
        logic word_set;   // write claim word with bit set
        logic word_clr;   // clear word at tail
        logic word_clr0;  // clear word zero
        logic restart;    // zero counter and start a clear sweep
        logic off_wr;     // write tail to offset of walk slot
        logic walk_step;  // advance cursor by one
        logic fill_all;   // start fill sweep with tail
        logic sweep_step; // one entry of clear or fill sweep
        logic set_cursor; // cursor := now
        logic cnt_zero;   // counter := 0
        logic issue;      // emit token, counter++
        logic capture_tail;
        logic res_load;   // move finished result to output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cmd;
        logic cursor_eq;
        logic cnt_low_zero;
        logic cnt_zero;
        logic horizon_zero;
        logic cursor_lt_hor;
        logic cursor_lt_now;
        logic gap_ge_life;
        logic at_limit;
        logic head_eq_tail;
        logic in_window;
        logic bit_set;
        logic mod_done;
        logic sweep_done;
    } t_sts;

endpackage

>>> rtl/one_time_token_issue_and_claim_top.sv
// ---------------------------------------------------------------------------
// one_time_token_issue_and_claim_top
// one-time token issue with replay-protected claim
// ---------------------------------------------------------------------------
// One word is taken at a time and answers with one result word; a finished
// result waits in an output register, so the next request word can be taken
// while it is held. A claim outside the window, a reserve within a second
// that needs no fresh claim word and a reserve on an idle counter are decided
// in the decode state. An in-window claim runs the serial remainder unit once.
// A reserve at a word boundary runs it twice, plus once per second it walks
// forward, or it sweeps the offset table instead when the gap is a whole
// lifetime and the table is refilled. A reserve that expires every second
// clears all LIFETIME_MAX offset entries. A held result that is not taken
// stalls the next word in its done state. The claim word ring needs no
// clearing pass.
module one_time_token_issue_and_claim_top #(
    parameter int STORE_WORDS  = otti_pkg::STORE_WORDS_DEF,
    parameter int LIFETIME_MAX = otti_pkg::LIFETIME_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data,     // lifetime[6:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [0:0]   s_axis_tuser,   // command
    input  logic [95:0]  s_axis_tdata,   // now_seconds, claim_bucket, claim_index
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // status, issued_bucket, issued_index, pad
);
    import otti_pkg::*;

    logic [6:0] r_lifetime;
    t_cmd cmd;
    t_sts sts;
    logic [1:0]  status;
    logic [31:0] ib, ii;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lifetime <= LIFETIME_RESET;
        else if (i_cfg_valid) r_lifetime <= i_cfg_data[6:0];
    end

    otti_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .o_res_status(status),
        .i_res_free  (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    otti_dp #(.STORE_WORDS(STORE_WORDS), .LIFETIME_MAX(LIFETIME_MAX)) u_dp (
        .i_clk, .i_rst_n,
        .i_lifetime     (r_lifetime),
        .i_word         ({s_axis_tdata, s_axis_tuser}),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_issued_bucket(ib),
        .o_issued_index (ii)
    );

    assign m_axis_tdata = {6'd0, ii, ib, status};

endmodule

>>> rtl/otti_ctrl.sv
// ---------------------------------------------------------------------------
// otti_ctrl
// sequencer for reserve and claim
// ---------------------------------------------------------------------------
module otti_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_res_valid,
    output logic [1:0]       o_res_status,
    input  logic             i_res_free,
    input  otti_pkg::t_sts   i_sts,
    output otti_pkg::t_cmd   o_cmd
);
    import otti_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_CMOD  = 4'd2;
    localparam logic [3:0] S_CRD   = 4'd3;
    localparam logic [3:0] S_CCHK  = 4'd4;
    localparam logic [3:0] S_SWEEP = 4'd5;
    localparam logic [3:0] S_HMOD  = 4'd6;
    localparam logic [3:0] S_HRD   = 4'd7;
    localparam logic [3:0] S_TMOD  = 4'd8;
    localparam logic [3:0] S_TRD   = 4'd9;
    localparam logic [3:0] S_DECR  = 4'd10;
    localparam logic [3:0] S_FILL  = 4'd11;
    localparam logic [3:0] S_WMOD  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic [1:0] r_res_status;
    logic       r_valid, n_valid;
    logic       r_wait, n_wait;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res_valid  = r_valid;
    assign o_res_status = r_res_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_valid  = r_valid && !i_res_free;
        n_wait   = 1'b0;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.cmd == CMD_CLAIM) begin
                    if (!i_sts.in_window) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.mod_start = 1'b1;
                        n_state = S_CMOD;
                    end
                end else if (i_sts.cursor_eq && !i_sts.cnt_low_zero) begin
                    o_cmd.issue = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (!i_sts.cursor_eq && !i_sts.cnt_zero &&
                             !i_sts.horizon_zero && i_sts.cursor_lt_hor) begin
                    o_cmd.restart = 1'b1;
                    n_state = S_SWEEP;
                end else if (i_sts.cnt_zero) begin
                    o_cmd.set_cursor = 1'b1;
                    o_cmd.word_clr0  = 1'b1;
                    o_cmd.issue      = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (i_sts.at_limit) begin
                    n_status = ST_RATE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel   = 1'b1;
                    n_state = S_HMOD;
                end
            end
            S_CMOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.off_rd = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                // offset registered; now read word
                if (!r_wait) begin
                    o_cmd.word_rd = 1'b1;
                    n_wait = 1'b1;
                end else begin
                    n_state = S_CCHK;
                end
            end
            S_CCHK: begin
                if (i_sts.bit_set) begin
                    n_status = ST_INVALID;
                end else begin
                    o_cmd.word_set = 1'b1;
                    n_status = ST_OK;
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                if (i_sts.sweep_done) begin
                    o_cmd.set_cursor = 1'b1;
                    o_cmd.word_clr0  = 1'b1;
                    o_cmd.issue      = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            S_HMOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.off_rd = 1'b1;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                // head captured; remainder of cursor for tail
                o_cmd.mod_start = 1'b1;
                n_state = S_TMOD;
            end
            S_TMOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.cur_rd = 1'b1;
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                o_cmd.capture_tail = 1'b1;
                n_state = S_DECR;
            end
            S_DECR: begin
                if (i_sts.head_eq_tail) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else if (!i_sts.cursor_lt_now) begin
                    o_cmd.word_clr = 1'b1;
                    o_cmd.issue    = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (i_sts.gap_ge_life) begin
                    o_cmd.cnt_zero = 1'b1;
                    o_cmd.fill_all = 1'b1;
                    n_state = S_FILL;
                end else begin
                    o_cmd.cnt_zero  = 1'b1;
                    o_cmd.walk_step = 1'b1;
                    o_cmd.mod_start = 1'b1;
                    n_state = S_WMOD;
                end
            end
            S_FILL: begin
                if (i_sts.sweep_done) begin
                    o_cmd.set_cursor = 1'b1;
                    o_cmd.word_clr   = 1'b1;
                    o_cmd.issue      = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            S_WMOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.off_wr = 1'b1;
                    if (i_sts.cursor_lt_now) begin
                        o_cmd.walk_step = 1'b1;
                        o_cmd.mod_start = 1'b1;
                    end else begin
                        n_state = S_DONE;
                        o_cmd.word_clr = 1'b1;
                        o_cmd.issue    = 1'b1;
                        n_status = ST_OK;
                    end
                end
            end
            S_DONE: begin
                // wait here while the previous result word is still held
                if (!r_valid || i_res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_wait  <= n_wait;
        end
        r_status <= n_status;
        if (o_cmd.res_load) r_res_status <= r_status;
    end

endmodule

>>> rtl/otti_dp.sv
// ---------------------------------------------------------------------------
// otti_dp
// claim word ring, offset table, counters and a serial remainder unit
// ---------------------------------------------------------------------------
module otti_dp #(
    parameter int STORE_WORDS  = otti_pkg::STORE_WORDS_DEF,
    parameter int LIFETIME_MAX = otti_pkg::LIFETIME_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [6:0]       i_lifetime,
    input  logic [96:0]      i_word,
    input  otti_pkg::t_cmd   i_cmd,
    output otti_pkg::t_sts   o_sts,
    output logic [31:0]      o_issued_bucket,
    output logic [31:0]      o_issued_index
);
    import otti_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam int LW = (LIFETIME_MAX > 1) ? $clog2(LIFETIME_MAX) : 1;
    localparam int LV = $clog2(LIFETIME_MAX + 1);

    logic [31:0] r_now, r_bucket, r_index, r_cursor, r_count;
    logic        r_cmd;
    logic [31:0] r_out_b, r_out_i;
    logic [31:0] r_res_b, r_res_i;
    logic [31:0] r_cword;

    logic [AW-1:0] r_off [LIFETIME_MAX];
    logic [AW-1:0] r_offv, r_head, r_tail, r_addr;

    // effective lifetime
    logic [LV-1:0] life;
    always_comb begin
        if (i_lifetime == 7'd0) life = LV'(1);
        else if (32'(i_lifetime) > 32'(LIFETIME_MAX)) life = LV'(LIFETIME_MAX);
        else life = LV'(i_lifetime);
    end
    logic [31:0] life32;
    assign life32 = 32'(life);

    logic [31:0] horizon, lower;
    always_comb begin
        horizon = r_now - life32 + 32'd1;
        if (horizon >= r_now) horizon = '0;
        lower = (r_now >= life32) ? r_now - life32 : '0;
    end

    // bit-serial remainder of a 32-bit value by lifetime
    logic [31:0] r_mq;
    logic [LV:0] r_mr;
    logic [5:0]  r_mcnt;
    logic        r_mbusy;
    logic [LV:0] m_trial;
    assign m_trial = {r_mr[LV-1:0], r_mq[31]};
    logic [31:0] mod_src;
    always_comb begin
        if (i_cmd.mod_sel) mod_src = horizon;
        else if (r_cmd == CMD_CLAIM) mod_src = r_bucket;
        else mod_src = r_cursor;
        // walk uses the cursor after its step
        if (i_cmd.walk_step) mod_src = r_cursor + 32'd1;
    end
    logic [LW-1:0] slot;
    assign slot = LW'(r_mr);

    // sweep over offsets
    logic [LV-1:0] r_sw;
    logic          r_fill;

    logic [31:0] tail_calc;
    assign tail_calc = 32'(r_offv) + ((r_count - 32'd1) >> 5) + 32'd1;

    logic [AW-1:0] claim_addr;
    assign claim_addr = AW'(32'(r_offv) + (r_index >> 5));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_word[0];
            r_now    <= i_word[32:1];
            r_bucket <= i_word[64:33];
            r_index  <= i_word[96:65];
        end
        if (i_cmd.mod_start) begin
            r_mq <= mod_src; r_mr <= '0; r_mcnt <= 6'd32; r_mbusy <= 1'b1;
        end else if (r_mbusy) begin
            if (r_mcnt == 6'd0) r_mbusy <= 1'b0;
            else begin
                r_mq   <= {r_mq[30:0], 1'b0};
                r_mr   <= (m_trial >= (LV+1)'(life)) ? m_trial - (LV+1)'(life) : m_trial;
                r_mcnt <= r_mcnt - 6'd1;
            end
        end
        if (i_cmd.off_rd) r_offv <= r_off[slot];
        if (i_cmd.cur_rd) r_offv <= r_off[slot];
        if (i_cmd.capture_tail) r_tail <= AW'(tail_calc);
        if (i_cmd.mod_start && !i_cmd.mod_sel && !i_cmd.walk_step) r_head <= r_offv;
        if (i_cmd.word_rd) r_addr <= claim_addr;
        if (i_cmd.issue) begin
            r_out_b <= r_now;
            r_out_i <= (i_cmd.cnt_zero) ? 32'd0 : r_count;
        end else if (i_cmd.load) begin
            r_out_b <= '0;
            r_out_i <= '0;
        end
        if (i_cmd.res_load) begin
            r_res_b <= r_out_b;
            r_res_i <= r_out_i;
        end
    end

    // claim word memory, one write and one registered read per cycle
    logic [31:0] mem_w [STORE_WORDS];
    logic [AW-1:0] wr_a;
    logic [31:0]   wr_d;
    logic          wr_e;
    always_comb begin
        wr_e = 1'b1;
        wr_a = r_addr;
        wr_d = r_cword | (32'd1 << r_index[4:0]);
        if (i_cmd.word_clr0) begin wr_a = '0; wr_d = '0; end
        else if (i_cmd.word_clr) begin wr_a = r_tail; wr_d = '0; end
        else if (!i_cmd.word_set) wr_e = 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (wr_e) mem_w[wr_a] <= wr_d;
        if (i_cmd.word_rd) r_cword <= mem_w[claim_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_count  <= '0;
            r_sw     <= '0;
            r_fill   <= 1'b0;
            for (int k = 0; k < LIFETIME_MAX; k++) r_off[k] <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_count <= '0; r_sw <= '0; r_fill <= 1'b0;
            end
            if (i_cmd.fill_all) begin
                r_sw <= '0; r_fill <= 1'b1;
            end
            if (i_cmd.sweep_step) begin
                r_off[LW'(r_sw)] <= r_fill ? r_tail : '0;
                r_sw <= r_sw + LV'(1);
            end
            if (i_cmd.walk_step) r_cursor <= r_cursor + 32'd1;
            if (i_cmd.off_wr) r_off[slot] <= r_tail;
            if (i_cmd.set_cursor) r_cursor <= r_now;
            if (i_cmd.issue)
                r_count <= (i_cmd.cnt_zero || (i_cmd.set_cursor && !r_fill))
                           ? 32'd1 : r_count + 32'd1;
            else if (i_cmd.cnt_zero) r_count <= '0;
        end
    end

    always_comb begin
        o_sts.cmd           = r_cmd;
        o_sts.cursor_eq     = (r_cursor == r_now);
        o_sts.cnt_low_zero  = (r_count[4:0] == 5'd0);
        o_sts.cnt_zero      = (r_count == '0);
        o_sts.horizon_zero  = (horizon == '0);
        o_sts.cursor_lt_hor = (r_cursor < horizon);
        o_sts.cursor_lt_now = (r_cursor < r_now);
        o_sts.gap_ge_life   = ((r_now - r_cursor) >= life32);
        o_sts.at_limit      = (r_count == COUNTER_LIMIT);
        o_sts.head_eq_tail  = (r_head == r_tail);
        o_sts.in_window     = (lower <= r_bucket) && (r_bucket <= r_now);
        o_sts.bit_set       = r_cword[r_index[4:0]];
        o_sts.mod_done      = r_mbusy && (r_mcnt == 6'd0);
        // a fill covers the live seconds, a clear covers the whole table
        o_sts.sweep_done    = r_fill ? (r_sw == life) : (r_sw == LV'(LIFETIME_MAX));
    end

    assign o_issued_bucket = r_res_b;
    assign o_issued_index  = r_res_i;

endmodule
